// ===== src/tbpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tbpq_pkg: shared constants for the two-level bucket priority queue
// Sizes of keys, digits, slots and counters, plus request and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tbpq_pkg;

	localparam int BUCKETS = 256;
	localparam int DIG_W   = $clog2(BUCKETS);
	localparam int BADDR_W = DIG_W + 1;          // {level, digit}, level 1 = top
	localparam int ENTRIES = 4096;
	localparam int SLOT_W  = $clog2(ENTRIES);
	localparam int CNT_W   = SLOT_W + 1;
	localparam int NODE_W  = 16;
	localparam int KEY_W   = 40;
	localparam int ROUND_W = KEY_W - 2 * DIG_W;

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_EXTRACT = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic LVL_LOW = 1'b0;
	localparam logic LVL_TOP = 1'b1;

endpackage

`default_nettype wire

// ===== src/tbpq_ram.sv =====
// ----------------------------------------------------------------------------
// tbpq_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpq_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/two_level_bucket_priority_queue.sv =====
// ----------------------------------------------------------------------------
// two_level_bucket_priority_queue: monotone bucket queue of (node, key) pairs
//
// A request is taken when start is high and busy is low. op selects insert,
// extract-minimum or clear; node and key matter for insert only. Every request
// produces one result: status, out_key, out_node and entry_count appear for
// exactly one cycle with done high. The receiver cannot stall; results must be
// taken as they come.
// Clear and rejected requests are answered straight from idle; an insert goes
// through one insert state; an extract scans the low buckets up from the
// current one, steps through the top buckets when the low level is empty, and
// spreads a top bucket into the low level entry by entry before the pop. busy
// stays high until the result cycle, so one request is in flight at a time; the
// linked lists live in the slot and bucket RAMs, each with one read and one write port.
// Reset and clear empty the queue at once: slot links are tracked with a
// high-water mark, so no clearing pass over the RAMs is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_bucket_priority_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  op,
	input  wire logic [tbpq_pkg::NODE_W-1:0] node,
	input  wire logic [tbpq_pkg::KEY_W-1:0]  key,
	output logic                             done,
	output logic      [1:0]                  status,
	output logic      [tbpq_pkg::KEY_W-1:0]  out_key,
	output logic      [tbpq_pkg::NODE_W-1:0] out_node,
	output logic      [tbpq_pkg::CNT_W-1:0]  entry_count
);

	typedef enum logic [3:0] {
		S_IDLE, S_INS, S_LSCAN, S_TSTEP, S_SP_RD, S_SP_HD, S_SP_ENT, S_SP_TL,
		S_SP_PUSH, S_POP, S_POP2, S_POP3
	} state_t;

	state_t state_q;

	logic [tbpq_pkg::BUCKETS-1:0] top_ne_q, low_ne_q;
	logic [tbpq_pkg::SLOT_W-1:0]  free_head_q;
	logic [tbpq_pkg::CNT_W-1:0]   hw_q;       // slots at or above this were never used
	logic [tbpq_pkg::CNT_W-1:0]   held_q;
	logic [tbpq_pkg::DIG_W-1:0]   cur_top_q, cur_low_q, start_top_q, d_q;
	logic [tbpq_pkg::ROUND_W-1:0] round_q;
	logic [tbpq_pkg::DIG_W:0]     j_q, lowest_q;
	logic                         final_q, same_q;
	logic [tbpq_pkg::SLOT_W-1:0]  s_q, last_q, next_q, h_q;
	logic [tbpq_pkg::BADDR_W-1:0] ins_addr_q;

	logic                         done_q;
	logic [1:0]                   status_q;
	logic [tbpq_pkg::KEY_W-1:0]   out_key_q;
	logic [tbpq_pkg::NODE_W-1:0]  out_node_q;

	// RAM ports
	logic                         lnk_we, nd_we, bhd_we, btl_we;
	logic [tbpq_pkg::SLOT_W-1:0]  lnk_waddr, lnk_wdata, lnk_raddr, lnk_rd;
	logic [tbpq_pkg::SLOT_W-1:0]  nd_raddr, dg_raddr;
	logic [tbpq_pkg::NODE_W-1:0]  nd_rd;
	logic [tbpq_pkg::DIG_W-1:0]   dg_rd;
	logic [tbpq_pkg::BADDR_W-1:0] bhd_waddr, bhd_raddr, btl_waddr, btl_raddr;
	logic [tbpq_pkg::SLOT_W-1:0]  bhd_wdata, btl_wdata, bhd_rd, btl_rd;

	logic                         accept, ins_ok, ins_ne, sp_ne, fresh;
	logic [tbpq_pkg::DIG_W-1:0]   key_lo, key_hi, nt;
	logic [tbpq_pkg::BADDR_W-1:0] key_addr;

	assign accept   = start && !busy;
	assign key_lo   = key[tbpq_pkg::DIG_W-1:0];
	assign key_hi   = key[2*tbpq_pkg::DIG_W-1:tbpq_pkg::DIG_W];
	assign key_addr = (key_hi != cur_top_q) ? {tbpq_pkg::LVL_TOP, key_hi}
	                                        : {tbpq_pkg::LVL_LOW, key_lo};
	assign ins_ok   = held_q < tbpq_pkg::CNT_W'(tbpq_pkg::ENTRIES);
	assign ins_ne   = ins_addr_q[tbpq_pkg::DIG_W]
	                  ? top_ne_q[ins_addr_q[tbpq_pkg::DIG_W-1:0]]
	                  : low_ne_q[ins_addr_q[tbpq_pkg::DIG_W-1:0]];
	assign sp_ne    = low_ne_q[d_q];
	assign fresh    = {1'b0, free_head_q} == hw_q;
	assign nt       = cur_top_q + tbpq_pkg::DIG_W'(1);

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign out_key     = out_key_q;
	assign out_node    = out_node_q;
	assign entry_count = held_q;

	// read address selection
	always_comb begin
		lnk_raddr = free_head_q;
		nd_raddr  = bhd_rd;
		dg_raddr  = s_q;
		bhd_raddr = {tbpq_pkg::LVL_LOW, cur_low_q};
		btl_raddr = {tbpq_pkg::LVL_LOW, cur_low_q};
		case (state_q)
			S_IDLE:   btl_raddr = key_addr;
			S_SP_ENT: lnk_raddr = s_q;
			S_SP_RD: begin
				bhd_raddr = {tbpq_pkg::LVL_TOP, cur_top_q};
				btl_raddr = {tbpq_pkg::LVL_TOP, cur_top_q};
			end
			S_SP_TL:  btl_raddr = {tbpq_pkg::LVL_LOW, dg_rd};
			S_POP2:   lnk_raddr = bhd_rd;
			default: ;
		endcase
	end

	// write ports
	always_comb begin
		lnk_we    = 1'b0;
		lnk_waddr = btl_rd;
		lnk_wdata = s_q;
		bhd_we    = 1'b0;
		bhd_waddr = {tbpq_pkg::LVL_LOW, d_q};
		bhd_wdata = s_q;
		btl_we    = 1'b0;
		btl_waddr = {tbpq_pkg::LVL_LOW, d_q};
		btl_wdata = s_q;
		nd_we     = accept && op == tbpq_pkg::OP_INSERT && ins_ok;
		case (state_q)
			S_INS: begin
				lnk_we    = ins_ne;
				lnk_wdata = free_head_q;
				bhd_we    = !ins_ne;
				bhd_waddr = ins_addr_q;
				bhd_wdata = free_head_q;
				btl_we    = 1'b1;
				btl_waddr = ins_addr_q;
				btl_wdata = free_head_q;
			end
			S_SP_PUSH: begin
				lnk_we = sp_ne;
				bhd_we = !sp_ne;
				btl_we = 1'b1;
			end
			S_POP3: begin
				// freed slot goes on top of the free list
				lnk_we    = 1'b1;
				lnk_waddr = h_q;
				lnk_wdata = free_head_q;
				bhd_we    = !same_q;
				bhd_waddr = {tbpq_pkg::LVL_LOW, cur_low_q};
				bhd_wdata = lnk_rd;
			end
			default: ;
		endcase
	end

	tbpq_ram #(.DEPTH(tbpq_pkg::ENTRIES), .WIDTH(tbpq_pkg::SLOT_W)) u_link (
		.clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
		.raddr(lnk_raddr), .rdata(lnk_rd)
	);

	tbpq_ram #(.DEPTH(tbpq_pkg::ENTRIES), .WIDTH(tbpq_pkg::NODE_W)) u_node (
		.clk(clk), .we(nd_we), .waddr(free_head_q), .wdata(node),
		.raddr(nd_raddr), .rdata(nd_rd)
	);

	tbpq_ram #(.DEPTH(tbpq_pkg::ENTRIES), .WIDTH(tbpq_pkg::DIG_W)) u_digit (
		.clk(clk), .we(nd_we), .waddr(free_head_q), .wdata(key_lo),
		.raddr(dg_raddr), .rdata(dg_rd)
	);

	tbpq_ram #(.DEPTH(2 * tbpq_pkg::BUCKETS), .WIDTH(tbpq_pkg::SLOT_W)) u_head (
		.clk(clk), .we(bhd_we), .waddr(bhd_waddr), .wdata(bhd_wdata),
		.raddr(bhd_raddr), .rdata(bhd_rd)
	);

	tbpq_ram #(.DEPTH(2 * tbpq_pkg::BUCKETS), .WIDTH(tbpq_pkg::SLOT_W)) u_tail (
		.clk(clk), .we(btl_we), .waddr(btl_waddr), .wdata(btl_wdata),
		.raddr(btl_raddr), .rdata(btl_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_ne_q    <= '0;
			low_ne_q    <= '0;
			free_head_q <= '0;
			hw_q        <= '0;
			held_q      <= '0;
			cur_top_q   <= '0;
			cur_low_q   <= '0;
			round_q     <= '0;
			done_q      <= 1'b0;
			status_q    <= tbpq_pkg::ST_DONE;
			out_key_q   <= '0;
			out_node_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q   <= tbpq_pkg::ST_DONE;
						out_key_q  <= '0;
						out_node_q <= '0;
						case (op)
							tbpq_pkg::OP_INSERT: begin
								if (ins_ok) begin
									ins_addr_q <= key_addr;
									state_q    <= S_INS;
								end else begin
									status_q <= tbpq_pkg::ST_FULL;
									done_q   <= 1'b1;
								end
							end
							tbpq_pkg::OP_EXTRACT: begin
								if (held_q == '0) begin
									status_q <= tbpq_pkg::ST_EMPTY;
									done_q   <= 1'b1;
								end else begin
									j_q     <= {1'b0, cur_low_q};
									final_q <= 1'b0;
									state_q <= S_LSCAN;
								end
							end
							tbpq_pkg::OP_CLEAR: begin
								top_ne_q    <= '0;
								low_ne_q    <= '0;
								free_head_q <= '0;
								hw_q        <= '0;
								held_q      <= '0;
								cur_top_q   <= '0;
								cur_low_q   <= '0;
								round_q     <= '0;
								done_q      <= 1'b1;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_INS: begin
					if (fresh) begin
						free_head_q <= tbpq_pkg::SLOT_W'(hw_q + tbpq_pkg::CNT_W'(1));
						hw_q        <= hw_q + tbpq_pkg::CNT_W'(1);
					end else begin
						free_head_q <= lnk_rd;
					end
					if (ins_addr_q[tbpq_pkg::DIG_W]) begin
						top_ne_q[ins_addr_q[tbpq_pkg::DIG_W-1:0]] <= 1'b1;
					end else begin
						low_ne_q[ins_addr_q[tbpq_pkg::DIG_W-1:0]] <= 1'b1;
					end
					held_q  <= held_q + tbpq_pkg::CNT_W'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_LSCAN: begin
					if (j_q[tbpq_pkg::DIG_W]) begin
						if (final_q) begin
							cur_low_q <= '0;
							state_q   <= S_POP;
						end else begin
							start_top_q <= cur_top_q;
							state_q     <= S_TSTEP;
						end
					end else if (low_ne_q[j_q[tbpq_pkg::DIG_W-1:0]]) begin
						cur_low_q <= j_q[tbpq_pkg::DIG_W-1:0];
						state_q   <= S_POP;
					end else begin
						j_q <= j_q + (tbpq_pkg::DIG_W + 1)'(1);
					end
				end
				S_TSTEP: begin
					cur_top_q <= nt;
					if (nt == '0) begin
						round_q <= round_q + tbpq_pkg::ROUND_W'(1);
					end
					if (top_ne_q[nt]) begin
						state_q <= S_SP_RD;
					end else if (nt == start_top_q) begin
						// full lap of the top level without a top bucket: rescan low level from zero
						j_q     <= '0;
						final_q <= 1'b1;
						state_q <= S_LSCAN;
					end
				end
				S_SP_RD: begin
					top_ne_q[cur_top_q] <= 1'b0;
					lowest_q            <= (tbpq_pkg::DIG_W + 1)'(tbpq_pkg::BUCKETS);
					state_q             <= S_SP_HD;
				end
				S_SP_HD: begin
					s_q     <= bhd_rd;
					last_q  <= btl_rd;
					state_q <= S_SP_ENT;
				end
				S_SP_ENT: state_q <= S_SP_TL;
				S_SP_TL: begin
					d_q    <= dg_rd;
					next_q <= lnk_rd;
					if ({1'b0, dg_rd} < lowest_q) begin
						lowest_q <= {1'b0, dg_rd};
					end
					state_q <= S_SP_PUSH;
				end
				S_SP_PUSH: begin
					low_ne_q[d_q] <= 1'b1;
					if (s_q == last_q) begin
						cur_low_q <= lowest_q[tbpq_pkg::DIG_W-1:0];
						state_q   <= S_POP;
					end else begin
						s_q     <= next_q;
						state_q <= S_SP_ENT;
					end
				end
				S_POP: state_q <= S_POP2;
				S_POP2: begin
					h_q     <= bhd_rd;
					same_q  <= bhd_rd == btl_rd;
					state_q <= S_POP3;
				end
				S_POP3: begin
					if (same_q) begin
						low_ne_q[cur_low_q] <= 1'b0;
					end
					out_node_q  <= nd_rd;
					out_key_q   <= {round_q, cur_top_q, cur_low_q};
					free_head_q <= h_q;
					held_q      <= held_q - tbpq_pkg::CNT_W'(1);
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result only appears once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe outside idle");

	a_held_le_hw: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= hw_q)
		else $error("more entries held than slots ever allocated");

	a_hw_range: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= tbpq_pkg::CNT_W'(tbpq_pkg::ENTRIES))
		else $error("high-water mark beyond slot count");

	a_req_answered: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done_q))
		else $error("request neither in progress nor answered");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> (held_q != '0 && low_ne_q[cur_low_q]))
		else $error("pop from empty low bucket");

endmodule

`default_nettype wire
